@@ src/rrsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rrsa_pkg: shared types and constants for the round-robin stripe allocator
// Field widths, operation and register codes, the remainder unit request,
// and the control program of the allocation sequencer.
// ----------------------------------------------------------------------------
package rrsa_pkg;

  // Default size of the order table and flag array
  localparam int MAX_TARGETS_DEF = 64;

  // Field widths
  localparam int OP_W    = 2;
  localparam int CNT_W   = 7;
  localparam int RND_W   = 32;
  localparam int TGT_W   = 6;
  localparam int POS_W   = 6;
  localparam int START_W = 8;
  localparam int SUM_W   = START_W + 1;
  localparam int CD_W    = 11;
  localparam int OFS_W   = 6;
  localparam int STEP_W  = 6;
  localparam int UPC_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Grant limit per allocation
  localparam logic [CNT_W-1:0] MAX_GRANT = 7'd64;

  // Reseed period: (RESEED_BASE / a + RESEED_EXTRA) * a
  localparam logic [CD_W-1:0] RESEED_BASE   = 11'd1000;
  localparam int              RESEED_BASE_W = 10;
  localparam logic [CD_W-1:0] RESEED_EXTRA  = 11'd4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 2'd0,
    OP_WRITE_SLOT = 2'd1,
    OP_SET_FLAG   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_COUNT = 1'd0,
    REG_ACTIVE_COUNT = 1'd1
  } reg_idx_t;

  // Request to the remainder unit; the dividend is MSB aligned
  typedef struct packed {
    logic              go;
    logic [RND_W-1:0]  dividend;
    logic [STEP_W-1:0] bits;
    logic [CNT_W-1:0]  divisor;
  } rem_req_t;

  // Control word fields
  typedef enum logic [1:0] {W_NONE, W_REQ, W_DIV, W_GRANT} wait_t;
  typedef enum logic [2:0] {SRC_NONE, SRC_RND, SRC_BASE, SRC_START, SRC_SUM} src_t;
  typedef enum logic [1:0] {DST_NONE, DST_START, DST_COUNTDOWN, DST_INDEX} dst_t;
  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_NOT_ALLOC, C_NO_RESEED, C_NO_WRAP, C_WALK_MORE
  } cond_t;

  typedef struct packed {
    wait_t            wt;
    src_t             src;
    dst_t             dst;
    logic             dec_cd;
    logic             inc_ofs;
    logic             walk;
    logic             flush;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // Program addresses
  localparam logic [UPC_W-1:0] UPC_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] UPC_CHECK    = 4'd1;
  localparam logic [UPC_W-1:0] UPC_SEED     = 4'd2;
  localparam logic [UPC_W-1:0] UPC_SEED_W   = 4'd3;
  localparam logic [UPC_W-1:0] UPC_RELOAD   = 4'd4;
  localparam logic [UPC_W-1:0] UPC_RELOAD_W = 4'd5;
  localparam logic [UPC_W-1:0] UPC_COUNT    = 4'd6;
  localparam logic [UPC_W-1:0] UPC_WRAP     = 4'd7;
  localparam logic [UPC_W-1:0] UPC_WRAP_W   = 4'd8;
  localparam logic [UPC_W-1:0] UPC_INDEX    = 4'd9;
  localparam logic [UPC_W-1:0] UPC_INDEX_W  = 4'd10;
  localparam logic [UPC_W-1:0] UPC_WALK     = 4'd11;
  localparam logic [UPC_W-1:0] UPC_FLUSH    = 4'd12;

  // Control store: one word per step, jump taken when cond holds
  function automatic ucw_t ucode(input logic [UPC_W-1:0] pc);
    ucw_t w;
    w         = '0;
    w.wt      = W_NONE;
    w.src     = SRC_NONE;
    w.dst     = DST_NONE;
    w.cond    = C_NEXT;
    w.target  = UPC_IDLE;
    unique case (pc)
      UPC_IDLE: begin
        w.wt = W_REQ; w.cond = C_NOT_ALLOC; w.target = UPC_IDLE;
      end
      UPC_CHECK: begin
        w.cond = C_NO_RESEED; w.target = UPC_COUNT;
      end
      UPC_SEED:     w.src = SRC_RND;
      UPC_SEED_W: begin
        w.wt = W_DIV; w.dst = DST_START;
      end
      UPC_RELOAD:   w.src = SRC_BASE;
      UPC_RELOAD_W: begin
        w.wt = W_DIV; w.dst = DST_COUNTDOWN; w.cond = C_ALWAYS; w.target = UPC_INDEX;
      end
      UPC_COUNT: begin
        w.dec_cd = 1'b1; w.cond = C_NO_WRAP; w.target = UPC_INDEX;
      end
      UPC_WRAP: begin
        w.src = SRC_START; w.inc_ofs = 1'b1;
      end
      UPC_WRAP_W: begin
        w.wt = W_DIV; w.dst = DST_START;
      end
      UPC_INDEX:    w.src = SRC_SUM;
      UPC_INDEX_W: begin
        w.wt = W_DIV; w.dst = DST_INDEX;
      end
      UPC_WALK: begin
        w.wt = W_GRANT; w.walk = 1'b1; w.cond = C_WALK_MORE; w.target = UPC_WALK;
      end
      UPC_FLUSH: begin
        w.wt = W_GRANT; w.flush = 1'b1; w.cond = C_ALWAYS; w.target = UPC_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ src/rrsa_ifs.sv @@
// ----------------------------------------------------------------------------
// rrsa_ifs: request and grant channels of the stripe allocator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rrsa_req_if import rrsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CNT_W-1:0]  wanted_count;
  logic [RND_W-1:0]  random_word;
  logic [TGT_W-1:0]  slot;
  logic [TGT_W-1:0]  target;
  logic              flag;

  modport source (output valid, operation, wanted_count, random_word, slot, target, flag,
                  input ready);
  modport sink   (input valid, operation, wanted_count, random_word, slot, target, flag,
                  output ready);
endinterface

interface rrsa_grant_if import rrsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TGT_W-1:0]  target_index;
  logic [POS_W-1:0]  position;
  logic [CNT_W-1:0]  granted_count;
  logic              last;
  logic              none_found;

  modport source (output valid, target_index, position, granted_count, last, none_found,
                  input ready);
  modport sink   (input valid, target_index, position, granted_count, last, none_found,
                  output ready);
endinterface

@@ src/rrsa_rem.sv @@
// ----------------------------------------------------------------------------
// rrsa_rem: restoring remainder unit
// Takes one dividend bit per cycle, MSB first, for the requested bit count.
// The remainder is valid once busy drops.
// ----------------------------------------------------------------------------
module rrsa_rem import rrsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  rem_req_t         req,
  output logic             busy,
  output logic [CNT_W-1:0] rem
);

  logic [RND_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Shift in the next bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[RND_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  // Load on request, then iterate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.go) begin
      busy  <= 1'b1;
      dvd   <= req.dividend;
      dsr   <= req.divisor;
      steps <= req.bits;
      rem   <= '0;
    end else if (busy) begin
      dvd   <= dvd << 1;
      rem   <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ src/round_robin_stripe_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_stripe_allocator_unit: round-robin stripe target allocator
// Table and flag writes are taken in the idle step, which stays ready. After an
// allocation is accepted the next item waits for the sequence: a reseed or a
// start wrap where needed, a remainder for the first slot, a walk of n slots
// (n at most the clamped target count) and a flush. The remainder unit takes one
// bit a cycle, the walk one slot a cycle while no grant stalls; a stall holds it.
// Synchronous reset: flags, start, offset and countdown clear, target_count
// is 1, active_count is 0; the order table holds garbage until written.
// ----------------------------------------------------------------------------
module round_robin_stripe_allocator_unit import rrsa_pkg::*; #(
  parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  rrsa_req_if.sink             req,
  rrsa_grant_if.source         grant
);

  localparam int AW = $clog2(MAX_TARGETS);
  localparam int IW = (AW > CNT_W) ? AW : CNT_W;

  // Sequencer
  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ucw_t             uw;
  logic             stall;
  logic             adv;
  logic             jump;

  // Configuration and allocator state
  logic [CNT_W-1:0]       target_count;
  logic [CNT_W-1:0]       active_count;
  logic [MAX_TARGETS-1:0] flags;
  logic [START_W-1:0]     start;
  logic [CD_W-1:0]        countdown;
  logic [OFS_W-1:0]       offset;
  logic [CNT_W-1:0]       wanted;
  logic [RND_W-1:0]       rnd;

  // Walk state
  logic [AW-1:0]    idx;
  logic [AW-1:0]    idx_inc;
  logic [IW-1:0]    idx_wide;
  logic [AW-1:0]    rd_addr;
  logic [TGT_W-1:0] rdata;
  logic [CNT_W-1:0] slot_cnt;
  logic [CNT_W-1:0] granted;
  logic             pend_valid;
  logic [TGT_W-1:0] pend_target;
  logic [POS_W-1:0] pend_pos;

  // Grant register
  logic             out_valid;
  logic             out_load;
  logic [TGT_W-1:0] out_target;
  logic [POS_W-1:0] out_pos;
  logic [CNT_W-1:0] out_gcount;
  logic             out_last;
  logic             out_none;

  // Derived values
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] act_eff;
  logic [CNT_W-1:0] limit;
  logic [SUM_W-1:0] sum;
  logic             wrap;
  logic             hit;
  logic             walk_end;
  logic             div_done;

  // Remainder unit
  rem_req_t         rem_req;
  logic             rem_busy;
  logic [CNT_W-1:0] rem;

  logic [TGT_W-1:0] order_mem [MAX_TARGETS];

  rrsa_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .req  (rem_req),
    .busy (rem_busy),
    .rem  (rem)
  );

  assign uw = ucode(upc);

  // Clamp configuration into usable ranges
  always_comb begin
    if (target_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (int'(target_count) > MAX_TARGETS) begin
      count_eff = CNT_W'(MAX_TARGETS);
    end else begin
      count_eff = target_count;
    end
    act_eff = (active_count == '0) ? CNT_W'(1) : active_count;
    limit   = (wanted > MAX_GRANT) ? MAX_GRANT : wanted;
    sum     = {1'b0, start} + SUM_W'(offset);
    wrap    = (wanted >= active_count) || (start > START_W'(count_eff));
  end

  // Walk step: test the slot read last cycle
  always_comb begin
    idx_wide = IW'(idx) + IW'(1);
    idx_inc  = (idx_wide == IW'(count_eff)) ? '0 : AW'(idx_wide);
    hit      = (int'(rdata) < MAX_TARGETS) && flags[AW'(rdata)] && (granted < limit);
    walk_end = ((slot_cnt + CNT_W'(1)) == count_eff) ||
               (hit && ((granted + CNT_W'(1)) == limit));
    div_done = (uw.wt == W_DIV) && !rem_busy;
  end

  // Stall, branch and next step
  always_comb begin
    unique case (uw.wt)
      W_REQ:   stall = !req.valid;
      W_DIV:   stall = rem_busy;
      W_GRANT: stall = out_valid && !grant.ready;
      default: stall = 1'b0;
    endcase
    adv = !stall;
    unique case (uw.cond)
      C_ALWAYS:    jump = 1'b1;
      C_NOT_ALLOC: jump = req.operation != OP_ALLOC;
      C_NO_RESEED: jump = countdown > CD_W'(1);
      C_NO_WRAP:   jump = !wrap;
      C_WALK_MORE: jump = !walk_end;
      default:     jump = 1'b0;
    endcase
    if (!adv) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
    out_load = adv && ((uw.walk && hit && pend_valid) || uw.flush);
  end

  // Launch remainder operations
  always_comb begin
    rem_req.go       = adv && (uw.src != SRC_NONE);
    rem_req.divisor  = count_eff;
    rem_req.dividend = rnd;
    rem_req.bits     = STEP_W'(RND_W);
    unique case (uw.src)
      SRC_BASE: begin
        rem_req.divisor  = act_eff;
        rem_req.dividend = RND_W'(RESEED_BASE) << (RND_W - RESEED_BASE_W);
        rem_req.bits     = STEP_W'(RESEED_BASE_W);
      end
      SRC_START: begin
        rem_req.dividend = RND_W'(start) << (RND_W - START_W);
        rem_req.bits     = STEP_W'(START_W);
      end
      SRC_SUM: begin
        rem_req.dividend = RND_W'(sum) << (RND_W - SUM_W);
        rem_req.bits     = STEP_W'(SUM_W);
      end
      default: ;
    endcase
  end

  // Table read address: first slot, next slot, or hold
  always_comb begin
    if (div_done && (uw.dst == DST_INDEX)) begin
      rd_addr = AW'(rem);
    end else if (uw.walk && adv) begin
      rd_addr = idx_inc;
    end else begin
      rd_addr = idx;
    end
  end

  // Order table
  always_ff @(posedge clk) begin
    if (adv && (uw.wt == W_REQ) && (req.operation == OP_WRITE_SLOT) &&
        (int'(req.slot) < MAX_TARGETS)) begin
      order_mem[AW'(req.slot)] <= req.target;
    end
    rdata <= order_mem[rd_addr];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= UPC_IDLE;
      target_count <= CNT_W'(1);
      active_count <= '0;
      flags        <= '0;
      start        <= '0;
      countdown    <= '0;
      offset       <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Load a new grant, or drop a delivered one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (grant.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_TARGET_COUNT: target_count <= cfg_data;
          REG_ACTIVE_COUNT: active_count <= cfg_data;
          default: ;
        endcase
      end

      if (adv) begin
        upc <= upc_next;

        // Take an item
        if (uw.wt == W_REQ) begin
          if ((req.operation == OP_SET_FLAG) && (int'(req.target) < MAX_TARGETS)) begin
            flags[AW'(req.target)] <= req.flag;
          end
          if (req.operation == OP_ALLOC) begin
            wanted <= req.wanted_count;
            rnd    <= req.random_word;
          end
        end

        if (uw.dec_cd) begin
          countdown <= countdown - CD_W'(1);
        end
        if (uw.inc_ofs) begin
          offset <= offset + OFS_W'(1);
        end

        // Store a finished remainder
        if (uw.wt == W_DIV) begin
          unique case (uw.dst)
            DST_START:     start <= START_W'(rem);
            DST_COUNTDOWN: countdown <= RESEED_BASE - CD_W'(rem) +
                                        CD_W'(act_eff) * RESEED_EXTRA;
            DST_INDEX: begin
              idx        <= AW'(rem);
              slot_cnt   <= '0;
              granted    <= '0;
              pend_valid <= 1'b0;
            end
            default: ;
          endcase
        end

        // Advance one slot; hold the newest grant back to mark the last one
        if (uw.walk) begin
          start    <= start + START_W'(1);
          idx      <= idx_inc;
          slot_cnt <= slot_cnt + CNT_W'(1);
          if (hit) begin
            granted     <= granted + CNT_W'(1);
            pend_valid  <= 1'b1;
            pend_target <= rdata;
            pend_pos    <= POS_W'(granted);
            if (pend_valid) begin
              out_target <= pend_target;
              out_pos    <= pend_pos;
              out_gcount <= {1'b0, pend_pos} + CNT_W'(1);
              out_last   <= 1'b0;
              out_none   <= 1'b0;
            end
          end
        end

        // Emit the final grant, or a none-found result
        if (uw.flush) begin
          out_last   <= 1'b1;
          pend_valid <= 1'b0;
          if (pend_valid) begin
            out_target <= pend_target;
            out_pos    <= pend_pos;
            out_gcount <= {1'b0, pend_pos} + CNT_W'(1);
            out_none   <= 1'b0;
          end else begin
            out_target <= '0;
            out_pos    <= '0;
            out_gcount <= '0;
            out_none   <= 1'b1;
          end
        end
      end
    end
  end

  assign req.ready           = (uw.wt == W_REQ);
  assign grant.valid         = out_valid;
  assign grant.target_index  = out_target;
  assign grant.position      = out_pos;
  assign grant.granted_count = out_gcount;
  assign grant.last          = out_last;
  assign grant.none_found    = out_none;

endmodule

@@ src/rrsa_check.sv @@
// ----------------------------------------------------------------------------
// rrsa_check: port-level checks for the stripe allocator
// Watches the request and grant channels and flags inconsistent results.
// ----------------------------------------------------------------------------
module rrsa_check import rrsa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [OP_W-1:0]  req_operation,
  input logic             grant_valid,
  input logic             grant_ready,
  input logic [TGT_W-1:0] target_index,
  input logic [POS_W-1:0] position,
  input logic [CNT_W-1:0] granted_count,
  input logic             last,
  input logic             none_found
);

  // Hold a stalled grant
  a_grant_hold: assert property (@(posedge clk) disable iff (rst)
    grant_valid && !grant_ready |=> grant_valid)
    else $error("grant dropped while stalled");

  // None-found results are final and carry zero fields
  a_none_fields: assert property (@(posedge clk) disable iff (rst)
    grant_valid && none_found |->
      last && (target_index == '0) && (position == '0) && (granted_count == '0))
    else $error("none-found result with nonzero fields");

  // Count tracks stripe number
  a_count_pos: assert property (@(posedge clk) disable iff (rst)
    grant_valid && !none_found |-> granted_count == ({1'b0, position} + CNT_W'(1)))
    else $error("granted count does not follow position");

  // An allocation keeps the request side closed
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_operation == OP_ALLOC) |=> !req_ready)
    else $error("request taken during allocation");

endmodule

bind round_robin_stripe_allocator_unit rrsa_check u_rrsa_check (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_operation (req.operation),
  .grant_valid   (grant.valid),
  .grant_ready   (grant.ready),
  .target_index  (grant.target_index),
  .position      (grant.position),
  .granted_count (grant.granted_count),
  .last          (grant.last),
  .none_found    (grant.none_found)
);
